FILE: rtl/core/ilid_pkg.sv
// ilid_pkg: shared types and constants for the indexed list insert/delete unit.
// Used by ilid_cell and indexed_list_insert_delete_unit; no dependencies.
package ilid_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] pos;
  } shift_ctrl_t;

endpackage

FILE: rtl/core/indexed_list_insert_delete_unit.sv
// indexed_list_insert_delete_unit: bounded ordered list with insert/delete at an index.
// out_valid strobes the cycle after start; one word per cycle.
// Throughput is set by the row of ilid_cell slots, which all shift in the same cycle.
// busy stays low; the receiver cannot stall, so no result is ever held back.
// Synchronous reset clears the count; slot contents are undefined until written.
// Depends on ilid_pkg and ilid_cell.
module indexed_list_insert_delete_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [ilid_pkg::POS_W-1:0]          in_position,
  input  logic signed [ilid_pkg::DATA_W-1:0]  in_value_in,
  output logic                                out_valid,
  output logic [ilid_pkg::STAT_W-1:0]         out_status,
  output logic signed [ilid_pkg::DATA_W-1:0]  out_removed_value,
  output logic [ilid_pkg::POS_W-1:0]          out_count_out
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      count_nxt;
  logic                               valid_r;
  ilid_pkg::status_t                  status_r;
  ilid_pkg::status_t                  status_nxt;
  logic signed [ilid_pkg::DATA_W-1:0] removed_r;
  logic signed [ilid_pkg::DATA_W-1:0] removed_nxt;
  logic signed [ilid_pkg::DATA_W-1:0] cell_val [CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0] cell_sel [CAPACITY];
  logic signed [ilid_pkg::DATA_W-1:0] read_word;
  ilid_pkg::shift_ctrl_t              ctrl;
  logic                               accept;
  logic [ilid_pkg::IDX_W-1:0]         pos_ext;
  logic [ilid_pkg::IDX_W-1:0]         cnt_ext;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_ext = ilid_pkg::IDX_W'(in_position);
  assign cnt_ext = ilid_pkg::IDX_W'(count_r);

  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | cell_sel[i];
    end
  end

  always_comb begin
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.pos    = pos_ext;
    count_nxt   = count_r;
    status_nxt  = ilid_pkg::ST_OK;
    removed_nxt = '0;
    case (in_cmd)
      ilid_pkg::CMD_INSERT: begin
        if (count_r >= CW'(CAPACITY)) begin
          status_nxt = ilid_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_nxt = ilid_pkg::ST_BADPOS;
        end else begin
          ctrl.ins  = accept;
          count_nxt = accept ? count_r + CW'(1) : count_r;
        end
      end
      ilid_pkg::CMD_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_nxt = ilid_pkg::ST_BADPOS;
        end else begin
          ctrl.del    = accept;
          count_nxt   = accept ? count_r - CW'(1) : count_r;
          removed_nxt = read_word;
        end
      end
      default: begin
        status_nxt = ilid_pkg::ST_BADPOS;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ilid_pkg::DATA_W-1:0] left_w;
    logic signed [ilid_pkg::DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_val[i+1];
    end
    ilid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (ilid_pkg::IDX_W'(i)),
      .value_in  (in_value_in),
      .left_val  (left_w),
      .right_val (right_w),
      .val       (cell_val[i]),
      .sel_val   (cell_sel[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_count_out     = ilid_pkg::POS_W'(count_r);

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("result strobe missing after accepted word");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result strobe without accepted word");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r != ilid_pkg::ST_OK) |->
      (out_removed_value == '0) && $stable(count_r))
    else $error("failed operation changed count or returned a word");

endmodule

FILE: rtl/core/ilid_cell.sv
// ilid_cell: one list slot; holds a word and shifts it to/from its neighbors.
// Depends on ilid_pkg.
module ilid_cell (
  input  logic                              clk,
  input  ilid_pkg::shift_ctrl_t             ctrl,
  input  logic [ilid_pkg::IDX_W-1:0]        cell_idx,
  input  logic signed [ilid_pkg::DATA_W-1:0] value_in,
  input  logic signed [ilid_pkg::DATA_W-1:0] left_val,
  input  logic signed [ilid_pkg::DATA_W-1:0] right_val,
  output logic signed [ilid_pkg::DATA_W-1:0] val,
  output logic signed [ilid_pkg::DATA_W-1:0] sel_val
);

  logic signed [ilid_pkg::DATA_W-1:0] val_r;
  logic signed [ilid_pkg::DATA_W-1:0] val_nxt;
  logic                               hit;
  logic                               above;

  assign hit   = (cell_idx == ctrl.pos);
  assign above = (cell_idx > ctrl.pos);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (hit) begin
        val_nxt = value_in;
      end else if (above) begin
        val_nxt = left_val;
      end
    end else if (ctrl.del) begin
      if (hit || above) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val     = val_r;
  assign sel_val = hit ? val_r : '0;

endmodule
